// ----- rtl/core/matrix_chain_order_assert.svh -----
// Assertion macros shared by the matrix chain order RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef MATRIX_CHAIN_ORDER_ASSERT_SVH
`define MATRIX_CHAIN_ORDER_ASSERT_SVH

// cond holds at every clock edge out of reset
`define MCO_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("mco check failed");

// cons holds in the cycle where ante holds
`define MCO_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mco check failed");

`endif

// ----- rtl/core/mco_pkg.sv -----
// Shared types and constants of the matrix chain order block.
// No dependencies.
package mco_pkg;

    localparam int IDX_OUT_W   = 4;
    localparam int COST_OUT_W  = 34;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [1:0] {
        DIM_I,
        DIM_J,
        DIM_K
    } t_dim_sel;

    typedef enum logic [1:0] {
        TAB_IK,
        TAB_KJ,
        TAB_WALK
    } t_tab_sel;

    typedef enum logic [1:0] {
        PUSH_ROOT,
        PUSH_SELF,
        PUSH_RIGHT,
        PUSH_LEFT
    } t_push_sel;

    typedef struct packed {
        logic      load_we;
        t_dim_sel  dim_sel;
        t_tab_sel  tab_sel;
        logic      latch_row;
        logic      latch_colj;
        logic      latch_a;
        logic      left_zero;
        logic      right_zero;
        logic      do_mul1;
        logic      do_mul2;
        logic      do_cmp;
        logic      first;
        logic      tab_we;
        logic      push;
        t_push_sel push_sel;
        logic      pop;
        logic      walk_latch;
        logic      walk_split;
        logic      emit;
        logic      emit_single;
    } t_dp_cmd;

    typedef struct packed {
        logic sp_zero;
        logic visited;
        logic push_right;
        logic push_left;
        logic out_valid;
    } t_dp_status;

endpackage

// ----- rtl/core/mco_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mco_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/mco_dp.sv -----
// Datapath of the matrix chain order block: dimension store, cost/split
// table, cost arithmetic, walk stack and output register. Uses mco_pkg, mco_ram.
`include "matrix_chain_order_assert.svh"

module mco_dp
    import mco_pkg::*;
#(
    parameter int MAX_MATRICES = 16,
    parameter int DIM_BITS     = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_dp_cmd                         i_cmd,
    output t_dp_status                      o_status,
    input  logic [$clog2(MAX_MATRICES)-1:0] i_idx_i,
    input  logic [$clog2(MAX_MATRICES)-1:0] i_idx_j,
    input  logic [$clog2(MAX_MATRICES)-1:0] i_idx_k,
    input  logic [$clog2(MAX_MATRICES)-1:0] i_load_addr,
    input  logic [DIM_BITS-1:0]             i_rows,
    input  logic [DIM_BITS-1:0]             i_cols,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]          o_m_axis_tdata,
    output logic                            o_m_axis_tlast
);

    localparam int IW  = $clog2(MAX_MATRICES);
    localparam int CW  = 3 * DIM_BITS + IW;
    localparam int PW1 = 2 * DIM_BITS;
    localparam int PW2 = 3 * DIM_BITS;
    localparam int TD  = 1 << (2 * IW);
    localparam int SD  = 2 * MAX_MATRICES;
    localparam int SAW = $clog2(SD);
    localparam int SW  = 2 * IW + 1;
    localparam int PAD = OUT_TDATA_W - 3 * IDX_OUT_W - COST_OUT_W;

    logic [PW1-1:0]      dim_rdata;
    logic [$clog2(MAX_MATRICES)-1:0] dim_raddr;
    logic [DIM_BITS-1:0] dim_row;
    logic [DIM_BITS-1:0] dim_col;

    logic [IW+CW-1:0]    tab_rdata;
    logic [2*IW-1:0]     tab_raddr;
    logic [IW-1:0]       tab_split;
    logic [CW-1:0]       tab_cost;
    logic [IW-1:0]       k_inc;

    logic [SW-1:0]       stk_rdata;
    logic [SW-1:0]       stk_wdata;
    logic [IW-1:0]       stk_x;
    logic [IW-1:0]       stk_y;
    logic                stk_v;
    logic [IW-1:0]       wk_inc;

    logic [CW-1:0]       cand;

    logic [DIM_BITS-1:0] r_row_i;
    logic [DIM_BITS-1:0] r_col_j;
    logic [DIM_BITS-1:0] r_col_k;
    logic [CW-1:0]       r_cost_a;
    logic [CW-1:0]       r_sum;
    logic [PW1-1:0]      r_p1;
    logic [PW2-1:0]      r_p2;
    logic [CW-1:0]       r_best;
    logic [IW-1:0]       r_bk;
    logic [CW-1:0]       r_run_cost;
    logic [IW-1:0]       r_wx;
    logic [IW-1:0]       r_wy;
    logic                r_wv;
    logic [IW-1:0]       r_wk;
    logic [SAW:0]        r_sp;
    logic                r_out_valid;
    logic                r_out_last;
    logic [OUT_TDATA_W-1:0] r_out_data;

    assign dim_row   = dim_rdata[PW1-1:DIM_BITS];
    assign dim_col   = dim_rdata[DIM_BITS-1:0];
    assign tab_split = tab_rdata[IW+CW-1:CW];
    assign tab_cost  = tab_rdata[CW-1:0];
    assign stk_x     = stk_rdata[SW-1:IW+1];
    assign stk_y     = stk_rdata[IW:1];
    assign stk_v     = stk_rdata[0];
    assign k_inc     = i_idx_k + IW'(1);
    assign wk_inc    = r_wk + IW'(1);
    assign cand      = r_sum + CW'(r_p2);

    always_comb begin
        unique case (i_cmd.dim_sel)
            DIM_I:   dim_raddr = i_idx_i;
            DIM_J:   dim_raddr = i_idx_j;
            DIM_K:   dim_raddr = i_idx_k;
            default: dim_raddr = i_idx_k;
        endcase
    end

    always_comb begin
        unique case (i_cmd.tab_sel)
            TAB_IK:   tab_raddr = {i_idx_i, i_idx_k};
            TAB_KJ:   tab_raddr = {k_inc, i_idx_j};
            TAB_WALK: tab_raddr = {stk_x, stk_y};
            default:  tab_raddr = {i_idx_i, i_idx_k};
        endcase
    end

    always_comb begin
        unique case (i_cmd.push_sel)
            PUSH_ROOT:  stk_wdata = {IW'(0), i_idx_j, 1'b0};
            PUSH_SELF:  stk_wdata = {r_wx, r_wy, 1'b1};
            PUSH_RIGHT: stk_wdata = {wk_inc, r_wy, 1'b0};
            PUSH_LEFT:  stk_wdata = {r_wx, r_wk, 1'b0};
            default:    stk_wdata = {r_wx, r_wy, 1'b1};
        endcase
    end

    mco_ram #(
        .WIDTH (PW1),
        .DEPTH (MAX_MATRICES)
    ) u_dim_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_we),
        .i_waddr (i_load_addr),
        .i_wdata ({i_rows, i_cols}),
        .i_raddr (dim_raddr),
        .o_rdata (dim_rdata)
    );

    mco_ram #(
        .WIDTH (IW + CW),
        .DEPTH (TD)
    ) u_tab_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tab_we),
        .i_waddr ({i_idx_i, i_idx_j}),
        .i_wdata ({r_bk, r_best}),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    mco_ram #(
        .WIDTH (SW),
        .DEPTH (SD)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_sp[SAW-1:0]),
        .i_wdata (stk_wdata),
        .i_raddr (SAW'(r_sp - 1'b1)),
        .o_rdata (stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_row) begin
            r_row_i <= dim_row;
        end
        if (i_cmd.latch_colj) begin
            r_col_j <= dim_col;
        end
        if (i_cmd.latch_a) begin
            r_col_k  <= dim_col;
            r_cost_a <= i_cmd.left_zero ? '0 : tab_cost;
        end
        if (i_cmd.do_mul1) begin
            r_sum <= r_cost_a + (i_cmd.right_zero ? '0 : tab_cost);
            r_p1  <= PW1'(r_row_i) * PW1'(r_col_k);
        end
        if (i_cmd.do_mul2) begin
            r_p2 <= PW2'(r_p1) * PW2'(r_col_j);
        end
        if (i_cmd.do_cmp && (i_cmd.first || cand <= r_best)) begin
            r_best <= cand;
            r_bk   <= i_idx_k;
        end
        if (i_cmd.tab_we) begin
            r_run_cost <= r_best;
        end
        if (i_cmd.walk_latch) begin
            r_wx <= stk_x;
            r_wy <= stk_y;
            r_wv <= stk_v;
        end
        if (i_cmd.walk_split) begin
            r_wk <= tab_split;
        end
        if (i_cmd.emit) begin
            r_out_data <= {PAD'(0), COST_OUT_W'(r_run_cost), IDX_OUT_W'(tab_split),
                           IDX_OUT_W'(r_wy), IDX_OUT_W'(r_wx)};
            r_out_last <= (r_sp == '0);
        end else if (i_cmd.emit_single) begin
            r_out_data <= '0;
            r_out_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_sp <= r_sp + 1'b1;
            end else if (i_cmd.pop) begin
                r_sp <= r_sp - 1'b1;
            end
            if (i_cmd.emit || i_cmd.emit_single) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.sp_zero    = (r_sp == '0);
    assign o_status.visited    = r_wv;
    assign o_status.push_right = ({1'b0, r_wk} + 1'b1) < {1'b0, r_wy};
    assign o_status.push_left  = (r_wx < r_wk);
    assign o_status.out_valid  = r_out_valid;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    `MCO_ASSERT_ALWAYS(a_sp_bound, r_sp <= (SAW+1)'(SD))
    `MCO_ASSERT_IMPLY(a_emit_free, i_cmd.emit || i_cmd.emit_single, !r_out_valid)
    `MCO_ASSERT_IMPLY(a_pop_nonempty, i_cmd.pop, r_sp != '0)

endmodule

// ----- rtl/core/mco_ctrl.sv -----
// Controller of the matrix chain order block: load counter, table fill
// sequencer and postorder walk sequencer. Uses mco_pkg.
`include "matrix_chain_order_assert.svh"

module mco_ctrl
    import mco_pkg::*;
#(
    parameter int MAX_MATRICES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tlast,
    output logic                            o_s_axis_tready,
    output t_dp_cmd                         o_cmd,
    input  t_dp_status                      i_status,
    output logic [$clog2(MAX_MATRICES)-1:0] o_idx_i,
    output logic [$clog2(MAX_MATRICES)-1:0] o_idx_j,
    output logic [$clog2(MAX_MATRICES)-1:0] o_idx_k,
    output logic [$clog2(MAX_MATRICES)-1:0] o_load_addr
);

    localparam int IW = $clog2(MAX_MATRICES);

    typedef enum logic [4:0] {
        S_LOAD, S_SINGLE,
        F_DIM, F_DIM2, F_DIM3, F_RA, F_RB, F_MUL, F_MUL2, F_CMP, F_WR,
        W_INIT, W_POP, W_TOP, W_SPL, W_PR, W_PL, W_OUT
    } t_state;

    t_state        r_state;
    logic [IW:0]   r_cnt;
    logic [IW-1:0] r_nm1;
    logic [IW-1:0] r_span;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_k;

    logic          accept;
    logic          store;
    logic [IW:0]   n_count;
    logic [IW-1:0] j;
    logic          k_more;

    assign accept  = i_s_axis_tvalid && (r_state == S_LOAD);
    assign store   = r_cnt < (IW+1)'(MAX_MATRICES);
    assign n_count = r_cnt + (IW+1)'(store);
    assign j       = r_i + r_span;
    assign k_more  = ({1'b0, r_k} + 1'b1) < {1'b0, j};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_nm1   <= '0;
            r_span  <= '0;
            r_i     <= '0;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        r_cnt <= n_count;
                        if (i_s_axis_tlast) begin
                            r_cnt  <= '0;
                            r_nm1  <= IW'(n_count - 1'b1);
                            r_span <= IW'(1);
                            r_i    <= '0;
                            r_state <= (n_count == (IW+1)'(1)) ? S_SINGLE : F_DIM;
                        end
                    end
                end
                S_SINGLE: r_state <= W_OUT;
                F_DIM:    r_state <= F_DIM2;
                F_DIM2:   r_state <= F_DIM3;
                F_DIM3: begin
                    r_k     <= r_i;
                    r_state <= F_RA;
                end
                F_RA:     r_state <= F_RB;
                F_RB:     r_state <= F_MUL;
                F_MUL:    r_state <= F_MUL2;
                F_MUL2:   r_state <= F_CMP;
                F_CMP: begin
                    if (k_more) begin
                        r_k     <= r_k + IW'(1);
                        r_state <= F_RA;
                    end else begin
                        r_state <= F_WR;
                    end
                end
                F_WR: begin
                    priority if (j < r_nm1) begin
                        r_i     <= r_i + IW'(1);
                        r_state <= F_DIM;
                    end else if (r_span < r_nm1) begin
                        r_span  <= r_span + IW'(1);
                        r_i     <= '0;
                        r_state <= F_DIM;
                    end else begin
                        r_state <= W_INIT;
                    end
                end
                W_INIT:   r_state <= W_POP;
                W_POP:    r_state <= i_status.sp_zero ? S_LOAD : W_TOP;
                W_TOP:    r_state <= W_SPL;
                W_SPL:    r_state <= i_status.visited ? W_OUT : W_PR;
                W_PR:     r_state <= W_PL;
                W_PL:     r_state <= W_POP;
                W_OUT:    r_state <= i_status.out_valid ? W_OUT : W_POP;
                default:  r_state <= S_LOAD;
            endcase
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.dim_sel    = DIM_K;
        o_cmd.tab_sel    = TAB_IK;
        o_cmd.push_sel   = PUSH_SELF;
        o_cmd.left_zero  = (r_k == r_i);
        o_cmd.right_zero = (r_k + IW'(1)) == j;
        o_cmd.first      = (r_k == r_i);
        unique case (r_state)
            S_LOAD:   o_cmd.load_we = accept && store;
            S_SINGLE: o_cmd.emit_single = 1'b1;
            F_DIM:    o_cmd.dim_sel = DIM_I;
            F_DIM2: begin
                o_cmd.dim_sel   = DIM_J;
                o_cmd.latch_row = 1'b1;
            end
            F_DIM3:   o_cmd.latch_colj = 1'b1;
            F_RA: begin
                o_cmd.dim_sel = DIM_K;
                o_cmd.tab_sel = TAB_IK;
            end
            F_RB: begin
                o_cmd.latch_a = 1'b1;
                o_cmd.tab_sel = TAB_KJ;
            end
            F_MUL:    o_cmd.do_mul1 = 1'b1;
            F_MUL2:   o_cmd.do_mul2 = 1'b1;
            F_CMP:    o_cmd.do_cmp = 1'b1;
            F_WR:     o_cmd.tab_we = 1'b1;
            W_INIT: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_ROOT;
            end
            W_POP:    o_cmd.pop = !i_status.sp_zero;
            W_TOP: begin
                o_cmd.walk_latch = 1'b1;
                o_cmd.tab_sel    = TAB_WALK;
            end
            W_SPL: begin
                o_cmd.walk_split = 1'b1;
                o_cmd.emit       = i_status.visited;
                o_cmd.push       = !i_status.visited;
                o_cmd.push_sel   = PUSH_SELF;
            end
            W_PR: begin
                o_cmd.push     = i_status.push_right;
                o_cmd.push_sel = PUSH_RIGHT;
            end
            W_PL: begin
                o_cmd.push     = i_status.push_left;
                o_cmd.push_sel = PUSH_LEFT;
            end
            W_OUT: ;
            default: ;
        endcase
    end

    assign o_s_axis_tready = (r_state == S_LOAD);
    assign o_idx_i         = r_i;
    assign o_idx_j         = (r_state == W_INIT) ? r_nm1 : j;
    assign o_idx_k         = r_k;
    assign o_load_addr     = r_cnt[IW-1:0];

    `MCO_ASSERT_ALWAYS(a_cnt_bound, r_cnt <= (IW+1)'(MAX_MATRICES))
    `MCO_ASSERT_IMPLY(a_split_range, r_state == F_RA, r_k < j && r_k >= r_i)
    `MCO_ASSERT_IMPLY(a_fill_in_chain, r_state == F_WR, j <= r_nm1)

endmodule

// ----- rtl/core/matrix_chain_order.sv -----
// Matrix chain order block: least-cost parenthesization of a chain of matrices.
// Top level; uses mco_pkg, mco_ctrl, mco_dp, mco_ram.
//
// Input stream: one matrix per transfer, tdata = {cols, rows}, tlast closes the
// chain. Transfers are taken one per cycle while loading; a pair beyond
// MAX_MATRICES is dropped, a dropped pair with tlast still closes the chain.
// After tlast the block fills the cost table bottom-up: per interval i..j it
// reads the dimensions, then per split candidate reads both subcosts through
// the single read port of the table memory, multiplies and compares, and
// finally writes the best split and cost. It then walks the split tree in
// postorder, emitting n-1 results (one for n = 1), each with the total cost;
// tlast marks the root. tready is low from tlast until the last result has
// been taken. A stalled output holds its result and pauses the walk. Reset
// empties the chain and drops any pending result; table memories need no
// clearing.
module matrix_chain_order
    import mco_pkg::*;
#(
    parameter int MAX_MATRICES = 16,
    parameter int DIM_BITS     = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // rows, cols
    input  logic [((2*DIM_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    input  logic                                 i_s_axis_tlast,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // seg_start, seg_end, split_at, total_cost
    output logic [OUT_TDATA_W-1:0]               o_m_axis_tdata,
    output logic                                 o_m_axis_tlast
);

    localparam int IW = $clog2(MAX_MATRICES);

    t_dp_cmd       cmd;
    t_dp_status    status;
    logic [IW-1:0] idx_i;
    logic [IW-1:0] idx_j;
    logic [IW-1:0] idx_k;
    logic [IW-1:0] load_addr;

    mco_ctrl #(
        .MAX_MATRICES (MAX_MATRICES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_s_axis_tready (o_s_axis_tready),
        .o_cmd           (cmd),
        .i_status        (status),
        .o_idx_i         (idx_i),
        .o_idx_j         (idx_j),
        .o_idx_k         (idx_k),
        .o_load_addr     (load_addr)
    );

    mco_dp #(
        .MAX_MATRICES (MAX_MATRICES),
        .DIM_BITS     (DIM_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_idx_i         (idx_i),
        .i_idx_j         (idx_j),
        .i_idx_k         (idx_k),
        .i_load_addr     (load_addr),
        .i_rows          (i_s_axis_tdata[DIM_BITS-1:0]),
        .i_cols          (i_s_axis_tdata[2*DIM_BITS-1:DIM_BITS]),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

// ----- tb/matrix_chain_order_tb.sv -----
// Self-checking testbench for matrix_chain_order: streams matrix chains in, predicts
// the least-cost split tree in postorder and compares every output transfer.
// Depends on mco_pkg and the matrix_chain_order RTL.
`timescale 1ns / 100ps

module matrix_chain_order_tb;
    import mco_pkg::*;

    localparam int MAXM = 16;
    localparam int DIMW = 10;
    localparam int IN_W = ((2*DIMW+7)/8)*8;
    localparam int LIMIT = 3000000;

    typedef struct packed {
        logic [DIMW-1:0] rows;
        logic [DIMW-1:0] cols;
        logic            last;
    } t_mat;

    typedef struct packed {
        logic [3:0]  seg_start;
        logic [3:0]  seg_end;
        logic [3:0]  split_at;
        logic [33:0] total_cost;
        logic        final_node;
    } t_node;

    logic i_clk, i_rst_n;
    logic i_s_axis_tvalid, o_s_axis_tready, i_s_axis_tlast;
    logic [IN_W-1:0] i_s_axis_tdata;
    logic o_m_axis_tvalid, i_m_axis_tready, o_m_axis_tlast;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    matrix_chain_order dut (.*);

    t_mat  mat_q[$];
    t_node node_q[$];
    int    errors = 0;
    int    cycles = 0;
    bit    stim_done = 0;
    bit    calm = 0;
    bit    hold_sink = 0;
    bit    hold_src = 0;

    logic [DIMW-1:0] row_mem[MAXM];
    logic [DIMW-1:0] col_mem[MAXM];
    longint unsigned cost_mem[MAXM][MAXM];
    int    split_mem[MAXM][MAXM];
    int    n_held = 0;
    longint unsigned chain_cost;

    task automatic walk_tree(int x, int y, bit root);
        int k;
        t_node nd;
        if (x >= y) return;
        k = split_mem[x][y];
        walk_tree(x, k, 0);
        walk_tree(k + 1, y, 0);
        nd.seg_start  = x[3:0];
        nd.seg_end    = y[3:0];
        nd.split_at   = k[3:0];
        nd.total_cost = chain_cost[33:0];
        nd.final_node = root;
        node_q.push_back(nd);
    endtask

    task automatic predict_chain(t_mat m);
        int n, j, bk;
        longint unsigned best, c;
        t_node nd;
        if (n_held < MAXM) begin
            row_mem[n_held] = m.rows;
            col_mem[n_held] = m.cols;
            n_held++;
        end
        if (!m.last) return;
        n = n_held;
        n_held = 0;
        if (n <= 1) begin
            nd = '0;
            nd.final_node = 1;
            node_q.push_back(nd);
            return;
        end
        for (int i = 0; i < n; i++) cost_mem[i][i] = 0;
        for (int len = 2; len <= n; len++) begin
            for (int i = 0; i + len - 1 < n; i++) begin
                j = i + len - 1;
                best = 0;
                bk = i;
                for (int k = i; k < j; k++) begin
                    c = cost_mem[i][k] + cost_mem[k+1][j]
                        + longint'(row_mem[i]) * col_mem[k] * col_mem[j];
                    if (k == i || c <= best) begin
                        best = c;
                        bk = k;
                    end
                end
                cost_mem[i][j] = best;
                split_mem[i][j] = bk;
            end
        end
        chain_cost = cost_mem[0][n-1];
        walk_tree(0, n - 1, 1);
    endtask

    function automatic logic [DIMW-1:0] rand_dim();
        case ($urandom_range(0, 5))
            0: return 1;
            1: return 1023;
            2: return $urandom_range(1, 15);
            default: return $urandom_range(1, 1023);
        endcase
    endfunction

    task automatic add_chain(int n);
        t_mat m;
        for (int i = 0; i < n; i++) begin
            m.rows = rand_dim();
            m.cols = rand_dim();
            m.last = (i == n - 1);
            mat_q.push_back(m);
        end
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_mat m;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                m = {i_s_axis_tdata[DIMW-1:0], i_s_axis_tdata[2*DIMW-1:DIMW], i_s_axis_tlast};
                predict_chain(m);
                void'(mat_q.pop_front());
            end
            if (!(i_s_axis_tvalid && !o_s_axis_tready)) begin
                if (mat_q.size() > 0 && !hold_src && (calm || $urandom_range(0, 99) >= 30)) begin
                    m = mat_q[0];
                    i_s_axis_tvalid <= 1;
                    i_s_axis_tdata  <= {{(IN_W-2*DIMW){1'b0}}, m.cols, m.rows};
                    i_s_axis_tlast  <= m.last;
                end else begin
                    i_s_axis_tvalid <= 0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_node got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.seg_start  = o_m_axis_tdata[3:0];
                got.seg_end    = o_m_axis_tdata[7:4];
                got.split_at   = o_m_axis_tdata[11:8];
                got.total_cost = o_m_axis_tdata[45:12];
                got.final_node = o_m_axis_tlast;
                if (node_q.size() == 0) begin
                    $error("unexpected result %h", o_m_axis_tdata);
                    errors++;
                end else begin
                    want = node_q.pop_front();
                    if (got.seg_start != want.seg_start) begin
                        $error("seg_start exp %0d got %0d", want.seg_start, got.seg_start);
                        errors++;
                    end
                    if (got.seg_end != want.seg_end) begin
                        $error("seg_end exp %0d got %0d", want.seg_end, got.seg_end);
                        errors++;
                    end
                    if (got.split_at != want.split_at) begin
                        $error("split_at exp %0d got %0d", want.split_at, got.split_at);
                        errors++;
                    end
                    if (got.total_cost != want.total_cost) begin
                        $error("total_cost exp %0d got %0d", want.total_cost,
                               got.total_cost);
                        errors++;
                    end
                    if (got.final_node != want.final_node) begin
                        $error("final_node exp %0d got %0d", want.final_node,
                               got.final_node);
                        errors++;
                    end
                end
            end
            i_m_axis_tready <= !hold_sink && (calm || $urandom_range(0, 99) >= 30);
        end
    end

    initial begin
        t_mat m;
        i_rst_n = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = '0;
        i_s_axis_tlast = 0;
        i_m_axis_tready = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: single matrix, extremes, ties, overfull store
        m = '{rows: 1, cols: 1, last: 1};
        mat_q.push_back(m);
        m = '{rows: 1023, cols: 1023, last: 1};
        mat_q.push_back(m);
        for (int i = 0; i < 3; i++) begin
            m = '{rows: 5, cols: 5, last: (i == 2)};
            mat_q.push_back(m);
        end
        for (int i = 0; i < 18; i++) begin
            m = '{rows: (i % 2) ? 10'h3ff : 10'h2aa, cols: (i % 2) ? 10'h155 : 10'h3ff,
                  last: (i == 17)};
            mat_q.push_back(m);
        end
        wait (mat_q.size() == 0 && node_q.size() == 0);

        // receiver stalls while the sender keeps offering
        hold_sink = 1;
        add_chain(4);
        add_chain(3);
        repeat (3000) @(posedge i_clk);
        hold_sink = 0;

        // sender pauses until every result is in
        wait (mat_q.size() == 0);
        hold_src = 1;
        wait (node_q.size() == 0);
        hold_src = 0;

        for (int t = 0; t < 80; t++) begin
            calm = (t >= 20 && t < 32);
            if ($urandom_range(0, 19) == 0) add_chain(MAXM + $urandom_range(1, 2));
            else add_chain($urandom_range(1, 8));
            wait (mat_q.size() < 4);
        end
        calm = 0;
        wait (mat_q.size() == 0 && node_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && node_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
